### rtl/bdlp_pkg.sv
// ---------------------------------------------------------------------------
// bdlp_pkg
// Shared types and constants for the button debounce / long-press block.
// ---------------------------------------------------------------------------
package bdlp_pkg;

    // Configuration register map (index into the register list)
    localparam int REG_DEBOUNCE   = 0;
    localparam int REG_LONG_PRESS = 1;

    // APB address width: two 16-bit registers, in 32-bit words at byte addresses 0 and 4
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_REG_W  = 16;

    // Register reset values
    localparam logic [CFG_REG_W-1:0] DEBOUNCE_RST   = 16'd30;
    localparam logic [CFG_REG_W-1:0] LONG_PRESS_RST = 16'd1000;

    // Input timestamp field width
    localparam int TIME_FIELD_W = 32;

    // Per-lane findings handed to the merge stage
    typedef struct packed {
        logic press;
        logic long_hit;
    } t_lane_res;

endpackage

### rtl/button_debounce_long_press.sv
// ---------------------------------------------------------------------------
// button_debounce_long_press
// Debounce and long-press detection for a group of active-low buttons.
//
// Usage:
//   Slave stream: one item per sample, tdata = {pin_levels, time_ms}.
//   Master stream: one result item per input item,
//     tdata = {long_held, press_events} padded to whole bytes.
//   APB port: debounce_ms at byte address 0, long_press_ms at address 4,
//     written while the block is idle.
// Latency: a result is valid the cycle after its input item is accepted.
// Throughput: one item per cycle while results are read; every button has its own
//   lane, and each lane does one subtract and compare per timer combinationally.
// Stall: results sit in one output register; the slave side takes a new
//   item only when that register is empty or being read in the same cycle,
//   so a stalled receiver holds the result and back-pressures the source.
// Reset: synchronous, active low; all buttons released, timers at zero,
//   registers at 30 ms and 1000 ms, output register empty.
// ---------------------------------------------------------------------------
module button_debounce_long_press
    import bdlp_pkg::*;
#(
    parameter int NUM_BUTTONS      = 4,
    parameter int NUM_LONG_BUTTONS = 3,
    parameter int TIME_BITS        = 32,
    localparam int IN_W  = ((TIME_FIELD_W + NUM_BUTTONS + 7) / 8) * 8,
    localparam int OUT_W = ((NUM_BUTTONS + NUM_LONG_BUTTONS + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input items
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_W-1:0]       s_axis_tdata,   // time_ms, pin_levels, zero pad
    // result items
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_W-1:0]      m_axis_tdata,   // press_events, long_held, zero pad
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [CFG_REG_W-1:0]        w_debounce_ms;
    logic [CFG_REG_W-1:0]        w_long_press_ms;
    logic                        w_accept;
    logic [TIME_BITS-1:0]        w_now;
    logic [NUM_BUTTONS-1:0]      w_pins;
    t_lane_res                   w_res [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0]      w_press;
    logic [NUM_LONG_BUTTONS-1:0] w_long;
    logic                        r_valid;
    logic [OUT_W-1:0]            r_tdata;

    bdlp_cfg u_cfg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_debounce_ms   (w_debounce_ms),
        .o_long_press_ms (w_long_press_ms)
    );

    assign s_axis_tready = !r_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_now         = s_axis_tdata[TIME_BITS-1:0];
    assign w_pins        = s_axis_tdata[TIME_FIELD_W +: NUM_BUTTONS];

    // one lane per button
    generate
        for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
            bdlp_lane #(
                .TIME_BITS (TIME_BITS),
                .HAS_LONG  (i < NUM_LONG_BUTTONS)
            ) u_lane (
                .i_clk           (i_clk),
                .i_rst_n         (i_rst_n),
                .i_en            (w_accept),
                .i_now           (w_now),
                .i_pin           (w_pins[i]),
                .i_debounce_ms   (w_debounce_ms),
                .i_long_press_ms (w_long_press_ms),
                .o_res           (w_res[i])
            );
            assign w_press[i] = w_res[i].press;
        end

        // merge long-press flags; buttons without a lane report zero
        for (genvar j = 0; j < NUM_LONG_BUTTONS; j++) begin : g_long
            if (j < NUM_BUTTONS) begin : g_hit
                assign w_long[j] = w_res[j].long_hit;
            end else begin : g_none
                assign w_long[j] = 1'b0;
            end
        end
    endgenerate

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_tdata <= OUT_W'({w_long, w_press});
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = r_tdata;

endmodule

### rtl/bdlp_cfg.sv
// ---------------------------------------------------------------------------
// bdlp_cfg
// APB register file holding the debounce time and the long-press hold time.
// ---------------------------------------------------------------------------
module bdlp_cfg
    import bdlp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [CFG_REG_W-1:0]  o_debounce_ms,
    output logic [CFG_REG_W-1:0]  o_long_press_ms
);

    logic                 w_wr;
    logic                 w_sel_deb;
    logic                 w_sel_long;
    logic [CFG_REG_W-1:0] r_debounce_ms;
    logic [CFG_REG_W-1:0] r_long_press_ms;

    assign pready     = 1'b1;
    assign w_wr       = psel && penable && pwrite && pready;
    // word index is the address bit above the byte offset
    assign w_sel_deb  = (paddr[CFG_ADDR_W-1] == 1'(REG_DEBOUNCE));
    assign w_sel_long = (paddr[CFG_ADDR_W-1] == 1'(REG_LONG_PRESS));

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms   <= DEBOUNCE_RST;
            r_long_press_ms <= LONG_PRESS_RST;
        end else if (w_wr) begin
            if (w_sel_deb) begin
                r_debounce_ms <= pwdata[CFG_REG_W-1:0];
            end
            if (w_sel_long) begin
                r_long_press_ms <= pwdata[CFG_REG_W-1:0];
            end
        end
    end

    // read mux
    always_comb begin
        if (w_sel_long) begin
            prdata = CFG_DATA_W'(r_long_press_ms);
        end else begin
            prdata = CFG_DATA_W'(r_debounce_ms);
        end
    end

    assign o_debounce_ms   = r_debounce_ms;
    assign o_long_press_ms = r_long_press_ms;

endmodule

### rtl/bdlp_lane.sv
// ---------------------------------------------------------------------------
// bdlp_lane
// One button: debounce timer, stable level and optional long-press timer.
// ---------------------------------------------------------------------------
module bdlp_lane
    import bdlp_pkg::*;
#(
    parameter int TIME_BITS = 32,
    parameter bit HAS_LONG  = 1'b1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic [TIME_BITS-1:0] i_now,
    input  logic                 i_pin,
    input  logic [CFG_REG_W-1:0] i_debounce_ms,
    input  logic [CFG_REG_W-1:0] i_long_press_ms,
    output t_lane_res            o_res
);

    logic                 r_prev;
    logic                 r_stable;
    logic [TIME_BITS-1:0] r_change_time;
    logic                 n_stable;
    logic [TIME_BITS-1:0] n_change_time;
    logic [TIME_BITS-1:0] w_elapsed;
    logic                 w_take;
    logic                 w_long_hit;

    // debounce: a changed reading restarts the timer
    always_comb begin
        n_change_time = (i_pin != r_prev) ? i_now : r_change_time;
        w_elapsed     = i_now - n_change_time;
        w_take        = (w_elapsed > TIME_BITS'(i_debounce_ms)) && (i_pin != r_stable);
        n_stable      = w_take ? i_pin : r_stable;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev        <= 1'b1;
            r_stable      <= 1'b1;
            r_change_time <= '0;
        end else if (i_en) begin
            r_prev        <= i_pin;
            r_stable      <= n_stable;
            r_change_time <= n_change_time;
        end
    end

    // long-press tracking on the raw low level
    generate
        if (HAS_LONG) begin : g_long
            logic                 r_held;
            logic [TIME_BITS-1:0] r_start;
            logic [TIME_BITS-1:0] n_start;
            logic [TIME_BITS-1:0] w_held_for;

            always_comb begin
                n_start    = (!i_pin && !r_held) ? i_now : r_start;
                w_held_for = i_now - n_start;
                w_long_hit = !i_pin && (w_held_for >= TIME_BITS'(i_long_press_ms));
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_held  <= 1'b0;
                    r_start <= '0;
                end else if (i_en) begin
                    r_held  <= !i_pin;
                    r_start <= n_start;
                end
            end
        end else begin : g_no_long
            assign w_long_hit = 1'b0;
        end
    endgenerate

    assign o_res.press    = w_take && !i_pin;
    assign o_res.long_hit = w_long_hit;

endmodule

### rtl/bdlp_checker.sv
// ---------------------------------------------------------------------------
// bdlp_checker
// Port-level checks for button_debounce_long_press, attached by bind.
// ---------------------------------------------------------------------------
module bdlp_checker
    import bdlp_pkg::*;
#(
    parameter int NUM_BUTTONS      = 4,
    parameter int NUM_LONG_BUTTONS = 3,
    localparam int IN_W  = ((TIME_FIELD_W + NUM_BUTTONS + 7) / 8) * 8,
    localparam int OUT_W = ((NUM_BUTTONS + NUM_LONG_BUTTONS + 7) / 8) * 8
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [IN_W-1:0]       s_axis_tdata,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_W-1:0]      m_axis_tdata
);

    logic                        w_in_acc;
    logic [NUM_BUTTONS-1:0]      w_pins;
    logic [NUM_LONG_BUTTONS-1:0] w_long_pins;

    assign w_in_acc = s_axis_tvalid && s_axis_tready;
    assign w_pins   = s_axis_tdata[TIME_FIELD_W +: NUM_BUTTONS];

    // pins seen by the long-press flags; missing buttons read as released
    generate
        for (genvar j = 0; j < NUM_LONG_BUTTONS; j++) begin : g_lp
            if (j < NUM_BUTTONS) begin : g_pin
                assign w_long_pins[j] = w_pins[j];
            end else begin : g_rel
                assign w_long_pins[j] = 1'b1;
            end
        end
    endgenerate

    // no result is left over from before reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // every accepted item yields a result in the next cycle
    a_result_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> m_axis_tvalid)
        else $error("accepted item gave no result");

    // a press is only reported for a button read low
    a_press_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (m_axis_tdata[NUM_BUTTONS-1:0] & $past(w_pins)) == '0)
        else $error("press reported on released button");

    // long-held is only reported for a button read low
    a_long_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=>
            (m_axis_tdata[NUM_BUTTONS +: NUM_LONG_BUTTONS] & $past(w_long_pins)) == '0)
        else $error("long-held reported on released button");

endmodule

bind button_debounce_long_press bdlp_checker #(
    .NUM_BUTTONS      (NUM_BUTTONS),
    .NUM_LONG_BUTTONS (NUM_LONG_BUTTONS)
) u_bdlp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

### tb/sv/button_debounce_long_press_checker.sv
// ---------------------------------------------------------------------------
// button_debounce_long_press_checker
// Watches the sample stream, the report stream and the APB port of the
// debounce block. Keeps its own copy of the per-button timers and register
// settings, predicts one report per accepted sample and compares each
// accepted report, field by field, with the oldest prediction.
// ---------------------------------------------------------------------------
module button_debounce_long_press_checker
    import bdlp_pkg::*;
#(
    parameter int IN_W  = 40,
    parameter int OUT_W = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [IN_W-1:0]       i_s_tdata,   // time_ms, pin_levels, zero pad
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [OUT_W-1:0]      i_m_tdata,   // press_events, long_held, zero pad
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [CFG_ADDR_W-1:0] i_paddr,
    input  logic [CFG_DATA_W-1:0] i_pwdata,
    input  logic [CFG_DATA_W-1:0] i_prdata,
    input  logic                  i_pready,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_checked
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BTN_N  = 4;
    localparam int LONG_N = 3;

    typedef struct packed {
        logic [LONG_N-1:0] long_held;
        logic [BTN_N-1:0]  press;
    } t_report;

    // shadow registers
    logic [CFG_REG_W-1:0] debounce_ms;
    logic [CFG_REG_W-1:0] hold_ms;

    // per-button debounce and long-press state
    logic [BTN_N-1:0]  last_pin;
    logic [BTN_N-1:0]  settled;
    logic [31:0]       edge_stamp [BTN_N];
    logic [LONG_N-1:0] was_low;
    logic [31:0]       low_since [LONG_N];

    t_report expected_reports[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    // One sample through the debounce and long-press logic
    task automatic predict_report(input logic [31:0] now, input logic [BTN_N-1:0] pins,
                                  output t_report rep);
        logic        rd;
        logic        low;
        logic [31:0] dt;
        rep = '0;
        for (int b = 0; b < BTN_N; b++) begin
            rd = pins[b];
            if (rd != last_pin[b])
                edge_stamp[b] = now;
            dt = now - edge_stamp[b];
            if (dt > {16'b0, debounce_ms} && rd != settled[b]) begin
                settled[b] = rd;
                if (!rd)
                    rep.press[b] = 1'b1;
            end
            last_pin[b] = rd;
            if (b < LONG_N) begin
                low = !rd;
                // press start follows the raw level, not the settled one
                if (low && !was_low[b])
                    low_since[b] = now;
                was_low[b] = low;
                dt = now - low_since[b];
                if (low && dt >= {16'b0, hold_ms})
                    rep.long_held[b] = 1'b1;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_report want;
        t_report got;
        logic [CFG_DATA_W-1:0] reg_val;
        if (!i_rst_n) begin
            debounce_ms = DEBOUNCE_RST;
            hold_ms     = LONG_PRESS_RST;
            last_pin    = '1;
            settled     = '1;
            was_low     = '0;
            for (int b = 0; b < BTN_N; b++)
                edge_stamp[b] = '0;
            for (int b = 0; b < LONG_N; b++)
                low_since[b] = '0;
            expected_reports.delete();
            o_pending = 0;
        end else begin
            // APB read-back
            if (i_psel && i_penable && !i_pwrite && i_pready) begin
                reg_val = '0;
                if (i_paddr == CFG_ADDR_W'(REG_DEBOUNCE * 4))
                    reg_val = {16'b0, debounce_ms};
                else if (i_paddr == CFG_ADDR_W'(REG_LONG_PRESS * 4))
                    reg_val = {16'b0, hold_ms};
                if (i_prdata !== reg_val) begin
                    $display("%0t: register read at 0x%0h: expected 0x%0h, got 0x%0h",
                             $time, i_paddr, reg_val, i_prdata);
                    o_fail_count++;
                end
            end
            // APB write
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr == CFG_ADDR_W'(REG_DEBOUNCE * 4))
                    debounce_ms = i_pwdata[CFG_REG_W-1:0];
                else if (i_paddr == CFG_ADDR_W'(REG_LONG_PRESS * 4))
                    hold_ms = i_pwdata[CFG_REG_W-1:0];
            end
            // report side: compare with the oldest prediction
            if (i_m_tvalid && i_m_tready) begin
                got = t_report'(i_m_tdata[BTN_N+LONG_N-1:0]);
                if (expected_reports.size() == 0) begin
                    $display("%0t: unexpected report: expected none, got 0x%0h",
                             $time, i_m_tdata);
                    o_fail_count++;
                end else begin
                    want = expected_reports.pop_front();
                    o_checked++;
                    if (got.press !== want.press) begin
                        $display("%0t: press_events: expected 0x%0h, got 0x%0h",
                                 $time, want.press, got.press);
                        o_fail_count++;
                    end
                    if (got.long_held !== want.long_held) begin
                        $display("%0t: long_held: expected 0x%0h, got 0x%0h",
                                 $time, want.long_held, got.long_held);
                        o_fail_count++;
                    end
                    if (i_m_tdata[OUT_W-1:BTN_N+LONG_N] !== '0) begin
                        $display("%0t: report pad bits: expected 0, got 0x%0h",
                                 $time, i_m_tdata[OUT_W-1:BTN_N+LONG_N]);
                        o_fail_count++;
                    end
                end
            end
            // sample side: predict
            if (i_s_tvalid && i_s_tready) begin
                predict_report(i_s_tdata[31:0], i_s_tdata[32+BTN_N-1:32], want);
                expected_reports.push_back(want);
            end
            o_pending = expected_reports.size();
        end
    end

endmodule

### tb/sv/button_debounce_long_press_tb.sv
// ---------------------------------------------------------------------------
// button_debounce_long_press_tb
// Stimulus and verdict for the button debounce / long-press block. Sends a
// directed set of samples (timestamp wrap, backward time, zero and full-scale
// times), then random bouncing button traffic under several register
// settings, with random stalls on both streams. The checker predicts and
// compares every report.
// ---------------------------------------------------------------------------
module button_debounce_long_press_tb;

    import bdlp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IN_W  = ((TIME_FIELD_W + 4 + 7) / 8) * 8;
    localparam int OUT_W = ((4 + 3 + 7) / 8) * 8;
    localparam int PHASE_ITEMS = 180;
    localparam int PHASE_N     = 6;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_W-1:0]       s_axis_tdata = '0;   // time_ms, pin_levels, zero pad
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_W-1:0]      m_axis_tdata;        // press_events, long_held, zero pad
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    int fail_count;
    int pending;
    int checked;

    // shaping state for the random traffic
    logic        calm = 1'b0;
    int unsigned stall_left = 0;
    int unsigned cur_debounce = 30;
    int unsigned cur_hold = 1000;
    int unsigned samples_sent = 0;
    logic [31:0] stamp;
    logic [3:0]  pins;

    int unsigned phase_debounce [PHASE_N];
    int unsigned phase_hold [PHASE_N];

    button_debounce_long_press dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    button_debounce_long_press_checker #(
        .IN_W  (IN_W),
        .OUT_W (OUT_W)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Report receiver: random stall bursts, none once the traffic is calm
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 3);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // One sample item; returns at the edge where it was accepted
    task automatic send_sample(input logic [31:0] t, input logic [3:0] p);
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, p, t};
        do @(posedge i_clk); while (!s_axis_tready);
        samples_sent++;
    endtask

    // Stop sending and wait for every outstanding report
    task automatic drain_reports();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(input int idx, input logic [CFG_DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(idx * 4);
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic read_reg(input int idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= CFG_ADDR_W'(idx * 4);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_times(input int unsigned deb, input int unsigned hold);
        write_reg(REG_DEBOUNCE, CFG_DATA_W'(deb));
        write_reg(REG_LONG_PRESS, CFG_DATA_W'(hold));
        read_reg(REG_DEBOUNCE);
        read_reg(REG_LONG_PRESS);
        cur_debounce = deb;
        cur_hold     = hold;
    endtask

    // Bounce-sized and short steps, some longer holds, a few jumps anywhere
    function automatic logic [31:0] next_stamp(input logic [31:0] t);
        int unsigned span;
        int unsigned pick;
        span = ((cur_debounce > cur_hold) ? cur_debounce : cur_hold) / 8 + 4;
        pick = $urandom_range(0, 99);
        if (pick < 3)
            return $urandom;
        if (pick < 13)
            return t + $urandom_range(0, 4 * span);
        if (pick < 53)
            return t + $urandom_range(0, cur_debounce / 2 + 1);
        return t + $urandom_range(0, span);
    endfunction

    function automatic logic [3:0] next_pins(input logic [3:0] p);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            return 4'($urandom);
        if (pick < 25)
            return p ^ (4'b1 << $urandom_range(0, 3));
        return p;
    endfunction

    initial begin
        phase_debounce = '{30, 0, 65535, 1, 0, 12};
        phase_hold     = '{1000, 0, 65535, 2, 0, 300};
        phase_debounce[4] = $urandom_range(0, 65535);
        phase_hold[4]     = $urandom_range(0, 65535);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        read_reg(REG_DEBOUNCE);
        read_reg(REG_LONG_PRESS);

        // directed: press after debounce, long hold, backward time, wrap
        send_sample(32'd0, 4'hF);
        send_sample(32'd31, 4'h0);
        send_sample(32'd62, 4'h0);
        send_sample(32'd1031, 4'h0);
        send_sample(32'd5, 4'h0);
        send_sample(32'd10, 4'hF);
        send_sample(32'd41, 4'hF);
        send_sample(32'hFFFF_FFFF, 4'h5);
        send_sample(32'hFFFF_FFFF, 4'hA);
        send_sample(32'h0000_001F, 4'hA);
        send_sample(32'h8000_0000, 4'hA);
        send_sample(32'h8000_0000, 4'hF);
        drain_reports();

        // directed: zero debounce and zero hold
        set_times(0, 0);
        send_sample(32'd100, 4'hE);
        send_sample(32'd100, 4'hE);
        send_sample(32'd101, 4'hE);
        send_sample(32'd101, 4'hF);
        send_sample(32'd102, 4'h0);
        send_sample(32'd102, 4'h0);
        send_sample(32'd103, 4'h0);
        drain_reports();

        // random bouncing traffic, one register setting per phase
        stamp = $urandom;
        pins  = 4'hF;
        for (int ph = 0; ph < PHASE_N; ph++) begin
            set_times(phase_debounce[ph], phase_hold[ph]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == PHASE_N - 1 && n == PHASE_ITEMS / 2)
                    calm = 1'b1;
                stamp = next_stamp(stamp);
                pins  = next_pins(pins);
                send_sample(stamp, pins);
            end
            drain_reports();
        end

        repeat (10) @(posedge i_clk);
        $display("Sent %0d samples over %0d register settings, incl. zero and full-scale times;",
                 samples_sent, PHASE_N + 2);
        $display("%0d reports checked, with wrapped and backward timestamps.", checked);
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Run limit
    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

### sim.f
rtl/bdlp_pkg.sv
rtl/bdlp_cfg.sv
rtl/bdlp_lane.sv
rtl/button_debounce_long_press.sv
rtl/bdlp_checker.sv
tb/sv/button_debounce_long_press_checker.sv
tb/sv/button_debounce_long_press_tb.sv
